@@ sv/hpg_pkg.sv @@
`default_nettype none

package hpg_pkg;

    // Fraction bits of the Gaussian sample held before scaling.
    localparam int NORMAL_FRAC_BITS = 28;
    localparam int LOG_FRAC         = 28;
    localparam int CORDIC_STEPS     = 30;
    localparam int ROOT_STEPS       = 32;
    localparam int NORM_STEPS       = 5;
    localparam int SQRT_SHIFT       = 2 * NORMAL_FRAC_BITS - 28;
    localparam int QUEUE_DEPTH      = 2;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);

    localparam logic [31:0] WEYL_STEP   = 32'h9e37_79b1;
    localparam logic [31:0] SEED_RESET  = 32'h1234_5678;
    localparam logic [31:0] MIX_MULT    = 32'h27d4_eb2d;
    localparam logic [31:0] MIX_XOR     = 32'd61;
    localparam logic [29:0] LN2_Q30     = 30'd744261118;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [29:0] GAIN_Q30    = 30'd652032874;

    // Operation codes as classified by the front end.
    localparam logic [2:0] OP_RAW   = 3'd0;
    localparam logic [2:0] OP_RANGE = 3'd1;
    localparam logic [2:0] OP_GAUSS = 3'd2;
    localparam logic [2:0] OP_LOAD  = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;
    localparam logic [2:0] OP_NONE  = 3'd5;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] low_bound;
        logic signed [31:0] high_bound;
        logic signed [31:0] std_dev;
        logic [31:0]        new_state;
    } hpg_item_t;

    typedef struct packed {
        logic      valid;
        hpg_item_t item;
    } hpg_queue_t;

    function automatic logic [31:0] mix32(input logic [31:0] k_in);
        logic [31:0] k;
        k = (k_in ^ MIX_XOR) ^ (k_in >> 16);
        k = k + (k << 3);
        k = k ^ (k >> 4);
        k = k * MIX_MULT;
        k = k ^ (k >> 15);
        return k;
    endfunction

    function automatic logic [31:0] seed_hash(input logic [31:0] seed);
        logic [31:0] v;
        v = mix32(seed);
        if (v == 32'd0)
        begin
            v = mix32(v);
        end
        return v;
    endfunction

    localparam logic [31:0] GEN_RESET = seed_hash(SEED_RESET);

    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] a;
        unique case (i)
            5'd0:  a = 30'd843314857;
            5'd1:  a = 30'd497837829;
            5'd2:  a = 30'd263043837;
            5'd3:  a = 30'd133525159;
            5'd4:  a = 30'd67021687;
            5'd5:  a = 30'd33543516;
            5'd6:  a = 30'd16775851;
            5'd7:  a = 30'd8388437;
            5'd8:  a = 30'd4194283;
            5'd9:  a = 30'd2097149;
            5'd10: a = 30'd1048575;
            default: a = 30'd1 << (5'd30 - i);
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

@@ sv/hpg_front.sv @@
`default_nettype none

module hpg_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [2:0]          kind,
    input  wire logic signed [31:0]  low_bound,
    input  wire logic signed [31:0]  high_bound,
    input  wire logic signed [31:0]  std_dev,
    input  wire logic [31:0]         new_state,
    output hpg_pkg::hpg_queue_t      q_head,
    input  wire logic                q_pop
);

    hpg_pkg::hpg_item_t             slot_reg [hpg_pkg::QUEUE_DEPTH];
    logic [hpg_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [hpg_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [hpg_pkg::QPTR_W:0]       count_reg, count_next;
    hpg_pkg::hpg_item_t             classified;
    logic                           push;
    logic                           pop;

    // Undefined kinds become a no-operation code.
    always_comb
    begin
        classified.low_bound  = low_bound;
        classified.high_bound = high_bound;
        classified.std_dev    = std_dev;
        classified.new_state  = new_state;
        if (kind > hpg_pkg::OP_READ)
        begin
            classified.op = hpg_pkg::OP_NONE;
        end
        else
        begin
            classified.op = kind;
        end
    end

    assign in_ready      = (count_reg != (hpg_pkg::QPTR_W+1)'(hpg_pkg::QUEUE_DEPTH));
    assign push          = in_valid && in_ready;
    assign pop           = q_pop && (count_reg != '0);
    assign q_head.valid  = (count_reg != '0);
    assign q_head.item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (hpg_pkg::QPTR_W+1)'(push) - (hpg_pkg::QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

`default_nettype wire

@@ sv/hpg_core.sv @@
`default_nettype none

module hpg_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [31:0]         cfg_data,
    input  wire hpg_pkg::hpg_queue_t q_head,
    output logic                     q_pop,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic signed [47:0]       value,
    output logic                     from_spare
);

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_SEED1     = 5'd1;
    localparam logic [4:0] S_SEED2     = 5'd2;
    localparam logic [4:0] S_RANGE_MUL = 5'd3;
    localparam logic [4:0] S_RANGE_FIN = 5'd4;
    localparam logic [4:0] S_DRAW2     = 5'd5;
    localparam logic [4:0] S_NORM      = 5'd6;
    localparam logic [4:0] S_LOG       = 5'd7;
    localparam logic [4:0] S_WMUL      = 5'd8;
    localparam logic [4:0] S_SQRT      = 5'd9;
    localparam logic [4:0] S_ZMUL      = 5'd10;
    localparam logic [4:0] S_CORDIC    = 5'd11;
    localparam logic [4:0] S_PSIN      = 5'd12;
    localparam logic [4:0] S_PCOS      = 5'd13;
    localparam logic [4:0] S_SCALE_MUL = 5'd14;
    localparam logic [4:0] S_SCALE_FIN = 5'd15;
    localparam logic [4:0] S_OUT       = 5'd16;

    logic [4:0]               state_reg, state_next;
    logic [4:0]               cnt_reg, cnt_next;
    logic [31:0]              gen_reg, gen_next;
    logic signed [31:0]       spare_reg, spare_next;
    logic                     spare_valid_reg, spare_valid_next;
    hpg_pkg::hpg_item_t       item_reg, item_next;
    logic [31:0]              word_reg, word_next;
    logic [31:0]              m_reg, m_next;
    logic [4:0]               p_reg, p_next;
    logic [27:0]              frac_reg, frac_next;
    logic [63:0]              big_reg, big_next;
    logic [63:0]              root_reg, root_next;
    logic signed [33:0]       cx_reg, cx_next;
    logic signed [33:0]       cy_reg, cy_next;
    logic signed [32:0]       cz_reg, cz_next;
    logic signed [31:0]       smp_reg, smp_next;
    logic                     neg_reg, neg_next;
    logic signed [47:0]       res_reg, res_next;
    logic                     flag_reg, flag_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [47:0]       value_reg, value_next;
    logic                     from_spare_reg, from_spare_next;

    logic [31:0]              draw_word;
    logic [31:0]              seed_mix;
    logic signed [32:0]       diff;
    logic [31:0]              mag;
    logic [63:0]              mul64;
    logic [32:0]              sq_top;
    logic [4:0]               amt;
    logic [33:0]              nl;
    logic [64:0]              trial;
    logic [63:0]              bitv;
    logic signed [33:0]       dx, dy;
    logic signed [33:0]       trig_s, trig_c;
    logic signed [66:0]       rprod;
    logic signed [36:0]       rshift;
    logic [32:0]              qv;
    logic signed [47:0]       lo48;
    logic signed [63:0]       sprod;
    logic signed [63:0]       sshift;

    function automatic logic signed [31:0] sat32(input logic signed [36:0] t);
        logic signed [31:0] r;
        if ((t[36:31] == 6'b000000) || (t[36:31] == 6'b111111))
        begin
            r = t[31:0];
        end
        else if (t[36])
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = 32'sh7fff_ffff;
        end
        return r;
    endfunction

    assign draw_word  = hpg_pkg::mix32(gen_reg + hpg_pkg::WEYL_STEP);
    assign seed_mix   = hpg_pkg::mix32(gen_reg);
    assign cfg_ready  = (state_reg == S_IDLE);
    assign q_pop      = (state_reg == S_IDLE) && !cfg_valid && q_head.valid;
    assign out_valid  = out_valid_reg;
    assign value      = value_reg;
    assign from_spare = from_spare_reg;

    // Datapath terms used by the individual states.
    always_comb
    begin
        diff   = 33'(item_reg.high_bound) - 33'(item_reg.low_bound);
        mag    = diff[32] ? 32'(-diff) : diff[31:0];
        mul64  = 64'(m_reg) * 64'(m_reg);
        sq_top = mul64[63:31];
        unique case (cnt_reg[2:0])
            3'd0:    amt = 5'd16;
            3'd1:    amt = 5'd8;
            3'd2:    amt = 5'd4;
            3'd3:    amt = 5'd2;
            default: amt = 5'd1;
        endcase
        nl     = {6'd32 - 6'(p_reg), 28'd0} - 34'(frac_reg);
        bitv   = 64'd1 << (6'd62 - {cnt_reg, 1'b0});
        trial  = 65'(root_reg) + 65'(bitv);
        dx     = cy_reg >>> cnt_reg;
        dy     = cx_reg >>> cnt_reg;
        unique case (word_reg[31:30])
            2'd0:    begin trig_c = cx_reg;  trig_s = cy_reg;  end
            2'd1:    begin trig_c = -cy_reg; trig_s = cx_reg;  end
            2'd2:    begin trig_c = -cx_reg; trig_s = -cy_reg; end
            default: begin trig_c = cy_reg;  trig_s = -cx_reg; end
        endcase
        rprod  = $signed({1'b0, root_reg[31:0]})
                 * ((state_reg == S_PSIN) ? trig_s : trig_c);
        rshift = 37'(rprod >>> 30);
        qv     = {1'b0, big_reg[63:32]} + 33'(neg_reg && (big_reg[31:0] != 32'd0));
        lo48   = 48'(item_reg.low_bound);
        sprod  = $signed(big_reg);
        sshift = sprod >>> hpg_pkg::NORMAL_FRAC_BITS;
    end

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        gen_next         = gen_reg;
        spare_next       = spare_reg;
        spare_valid_next = spare_valid_reg;
        item_next        = item_reg;
        word_next        = word_reg;
        m_next           = m_reg;
        p_next           = p_reg;
        frac_next        = frac_reg;
        big_next         = big_reg;
        root_next        = root_reg;
        cx_next          = cx_reg;
        cy_next          = cy_reg;
        cz_next          = cz_reg;
        smp_next         = smp_reg;
        neg_next         = neg_reg;
        res_next         = res_reg;
        flag_next        = flag_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        value_next       = value_reg;
        from_spare_next  = from_spare_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    gen_next         = cfg_data;
                    spare_valid_next = 1'b0;
                    spare_next       = '0;
                    state_next       = S_SEED1;
                end
                else if (q_head.valid)
                begin
                    item_next = q_head.item;
                    flag_next = 1'b0;
                    res_next  = '0;
                    state_next = S_OUT;
                    unique case (q_head.item.op)
                        hpg_pkg::OP_RAW:
                        begin
                            gen_next = draw_word;
                            res_next = 48'(draw_word);
                        end
                        hpg_pkg::OP_RANGE:
                        begin
                            gen_next   = draw_word;
                            word_next  = draw_word;
                            state_next = S_RANGE_MUL;
                        end
                        hpg_pkg::OP_GAUSS:
                        begin
                            if (spare_valid_reg)
                            begin
                                smp_next         = spare_reg;
                                spare_valid_next = 1'b0;
                                spare_next       = '0;
                                flag_next        = 1'b1;
                                state_next       = S_SCALE_MUL;
                            end
                            else
                            begin
                                gen_next   = draw_word;
                                m_next     = (draw_word == 32'd0) ? 32'd1 : draw_word;
                                p_next     = 5'd31;
                                state_next = S_DRAW2;
                            end
                        end
                        hpg_pkg::OP_LOAD:
                        begin
                            gen_next         = q_head.item.new_state;
                            spare_valid_next = 1'b0;
                            spare_next       = '0;
                            res_next         = 48'(q_head.item.new_state);
                        end
                        hpg_pkg::OP_READ:
                        begin
                            res_next = 48'(gen_reg);
                        end
                        default:
                        begin
                            res_next = '0;
                        end
                    endcase
                end
            end
            S_SEED1:
            begin
                gen_next   = seed_mix;
                state_next = S_SEED2;
            end
            S_SEED2:
            begin
                if (gen_reg == 32'd0)
                begin
                    gen_next = seed_mix;
                end
                state_next = S_IDLE;
            end
            S_RANGE_MUL:
            begin
                big_next   = 64'(word_reg) * 64'(mag);
                neg_next   = diff[32];
                state_next = S_RANGE_FIN;
            end
            S_RANGE_FIN:
            begin
                res_next   = neg_reg ? lo48 - 48'(qv) : lo48 + 48'(qv);
                state_next = S_OUT;
            end
            S_DRAW2:
            begin
                gen_next   = draw_word;
                word_next  = draw_word;
                cnt_next   = '0;
                state_next = S_NORM;
            end
            S_NORM:
            begin
                if ((m_reg & ~(32'hffff_ffff >> amt)) == 32'd0)
                begin
                    m_next = m_reg << amt;
                    p_next = p_reg - amt;
                end
                if (cnt_reg == 5'(hpg_pkg::NORM_STEPS - 1))
                begin
                    cnt_next   = '0;
                    frac_next  = '0;
                    state_next = S_LOG;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            S_LOG:
            begin
                if (sq_top[32])
                begin
                    m_next    = sq_top[32:1];
                    frac_next = {frac_reg[26:0], 1'b1};
                end
                else
                begin
                    m_next    = sq_top[31:0];
                    frac_next = {frac_reg[26:0], 1'b0};
                end
                if (cnt_reg == 5'(hpg_pkg::LOG_FRAC - 1))
                begin
                    state_next = S_WMUL;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            S_WMUL:
            begin
                big_next   = ((64'(nl) * 64'(hpg_pkg::LN2_Q30)) >> 29) << hpg_pkg::SQRT_SHIFT;
                root_next  = '0;
                cnt_next   = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                if (65'(big_reg) >= trial)
                begin
                    big_next  = big_reg - trial[63:0];
                    root_next = (root_reg >> 1) + bitv;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                if (cnt_reg == 5'(hpg_pkg::ROOT_STEPS - 1))
                begin
                    state_next = S_ZMUL;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            S_ZMUL:
            begin
                big_next   = 64'(word_reg[29:0]) * 64'(hpg_pkg::HALF_PI_Q30);
                state_next = S_CORDIC;
                cnt_next   = '0;
                cx_next    = 34'(hpg_pkg::GAIN_Q30);
                cy_next    = '0;
                cz_next    = {2'b00, big_next[60:30]};
            end
            S_CORDIC:
            begin
                if (!cz_reg[32])
                begin
                    cx_next = cx_reg - dx;
                    cy_next = cy_reg + dy;
                    cz_next = cz_reg - $signed({3'b000, hpg_pkg::atan_q30(cnt_reg)});
                end
                else
                begin
                    cx_next = cx_reg + dx;
                    cy_next = cy_reg - dy;
                    cz_next = cz_reg + $signed({3'b000, hpg_pkg::atan_q30(cnt_reg)});
                end
                if (cnt_reg == 5'(hpg_pkg::CORDIC_STEPS - 1))
                begin
                    state_next = S_PSIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            S_PSIN:
            begin
                smp_next   = sat32(rshift);
                state_next = S_PCOS;
            end
            S_PCOS:
            begin
                spare_next       = sat32(rshift);
                spare_valid_next = 1'b1;
                state_next       = S_SCALE_MUL;
            end
            S_SCALE_MUL:
            begin
                big_next   = 64'(smp_reg * item_reg.std_dev);
                state_next = S_SCALE_FIN;
            end
            S_SCALE_FIN:
            begin
                if ((sshift[63:47] == '0) || (sshift[63:47] == '1))
                begin
                    res_next = sshift[47:0];
                end
                else if (sshift[63])
                begin
                    res_next = 48'sh8000_0000_0000;
                end
                else
                begin
                    res_next = 48'sh7fff_ffff_ffff;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    value_next      = res_reg;
                    from_spare_next = flag_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            gen_reg         <= hpg_pkg::GEN_RESET;
            spare_reg       <= '0;
            spare_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            gen_reg         <= gen_next;
            spare_reg       <= spare_next;
            spare_valid_reg <= spare_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        word_reg       <= word_next;
        m_reg          <= m_next;
        p_reg          <= p_next;
        frac_reg       <= frac_next;
        big_reg        <= big_next;
        root_reg       <= root_next;
        cx_reg         <= cx_next;
        cy_reg         <= cy_next;
        cz_reg         <= cz_next;
        smp_reg        <= smp_next;
        neg_reg        <= neg_next;
        res_reg        <= res_next;
        flag_reg       <= flag_next;
        value_reg      <= value_next;
        from_spare_reg <= from_spare_next;
    end

endmodule

`default_nettype wire

@@ sv/hash_prng_with_gaussian_unit.sv @@
`default_nettype none

// Hashed Weyl-sequence random generator with a fixed-point Gaussian unit. Each
// input word names one request (raw draw, range draw, Gaussian draw, state load
// or state read) and produces exactly one output word. A two-entry request queue
// sits in front of a sequential execution engine, and the engine ends in an
// output register, so a new request can be taken while a result waits. Raw
// draws, loads and reads go straight to the output stage, range draws add a
// multiply and a finish step, a Gaussian draw served from the cached spare
// adds a scaling multiply and a finish step, and a fresh Gaussian pair runs
// the engine's iterative units one after another: a 5-step leading-one search,
// a 28-step squaring log2, a 32-step square root and a 30-step CORDIC rotation.
// The engine handles one request at a time. Writing the seed register is
// accepted only while the engine is idle; after reset the generator already
// holds the hash of the default seed, so no start-up sequence is needed.

module hash_prng_with_gaussian_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [31:0]         cfg_data,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [2:0]          kind,
    input  wire logic signed [31:0]  low_bound,
    input  wire logic signed [31:0]  high_bound,
    input  wire logic signed [31:0]  std_dev,
    input  wire logic [31:0]         new_state,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic signed [47:0]       value,
    output logic                     from_spare
);

    // Queue head as seen by the engine, and the engine's pop strobe.
    hpg_pkg::hpg_queue_t q_head;
    logic                q_pop;

    // The front end decodes each incoming word into an operation code and
    // buffers it, so the upstream side is never held by a busy engine until
    // the queue is full.
    hpg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .low_bound  (low_bound),
        .high_bound (high_bound),
        .std_dev    (std_dev),
        .new_state  (new_state),
        .q_head     (q_head),
        .q_pop      (q_pop)
    );

    // The engine owns the generator state, the cached spare sample and the
    // output register.
    hpg_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .value      (value),
        .from_spare (from_spare)
    );

endmodule

`default_nettype wire

@@ sv/hpg_checker.sv @@
`default_nettype none

module hpg_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               cfg_valid,
    input wire logic               cfg_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic signed [47:0] value,
    input wire logic               from_spare
);

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value) && $stable(from_spare))
        else $error("output word changed while stalled");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("output valid right after reset");

    // A seed write keeps the engine busy rehashing on the next cycle.
    a_seed_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !cfg_ready)
        else $error("seed port ready during rehash");

endmodule

bind hash_prng_with_gaussian_unit hpg_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value),
    .from_spare (from_spare)
);

`default_nettype wire
